// File: rtl/osbfir_pkg.sv
// Shared types, constants and the Q15 round/saturate helper for the block FIR.
// No dependencies; the filter engine and the top level import this package.
`default_nettype none

package osbfir_pkg;

  localparam int SAMP_W    = 16;
  localparam int BLOCK_LEN = 25;
  // Sample ring depth; must cover one block plus TAPS-1 history samples.
  localparam int FFT_LEN   = 32;
  localparam int TAPS      = 8;
  localparam int NUM_COEF  = 8;

  localparam int POS_W     = $clog2(BLOCK_LEN);
  localparam int SAMP_AW   = $clog2(FFT_LEN);
  localparam int TAP_W     = $clog2(TAPS);
  localparam int PROD_W    = 2 * SAMP_W;
  localparam int ACC_W     = PROD_W + TAP_W;
  localparam int CFG_IDX_W = 4;

  // Rounded Q30 sums at or above this value, or below its negative, clamp.
  localparam longint SAT_LIM = longint'(1) << (PROD_W - 2);
  localparam longint RND_HALF = longint'(1) << (SAMP_W - 2);

  typedef logic signed [SAMP_W-1:0] sample_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_FILTER
  } state_t;

  typedef struct packed {
    logic               start;
    logic [SAMP_AW-1:0] base;
    logic               primed;
  } eng_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } eng_stat_t;

  typedef struct packed {
    logic             we;
    logic [POS_W-1:0] addr;
    sample_t          data;
  } play_wr_t;

  // Round Q30 to Q15 (add half, floor) and clamp to the 16-bit range.
  function automatic sample_t round_sat_q15(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W:0] r;
    logic signed [ACC_W:0] q;
    r = (ACC_W+1)'(acc) + (ACC_W+1)'(RND_HALF);
    q = r >>> (SAMP_W - 1);
    if (r >= SAT_LIM) begin
      return sample_t'({1'b0, {(SAMP_W-1){1'b1}}});
    end else if (r < -SAT_LIM) begin
      return sample_t'({1'b1, {(SAMP_W-1){1'b0}}});
    end else begin
      return q[SAMP_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// File: rtl/osbfir_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module osbfir_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // Hold read data while no read is issued.
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/osbfir_mac.sv
// Block filter engine: walks outputs and taps, reads the sample ring, runs a
// multiply-accumulate pipeline and writes rounded results to the play RAM.
// Depends on osbfir_pkg.
`default_nettype none

module osbfir_mac (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire osbfir_pkg::eng_ctrl_t            ctrl,
  input  wire osbfir_pkg::sample_t              coef [osbfir_pkg::TAPS],
  output logic                                  samp_re,
  output logic [osbfir_pkg::SAMP_AW-1:0]        samp_raddr,
  input  wire logic [osbfir_pkg::SAMP_W-1:0]    samp_rdata,
  output osbfir_pkg::play_wr_t                  play_wr,
  output osbfir_pkg::eng_stat_t                 stat
);
  import osbfir_pkg::*;

  // Sequencer
  logic               running;
  logic [SAMP_AW-1:0] base;
  logic               primed;
  logic [POS_W-1:0]   idx;
  logic [TAP_W-1:0]   tap;

  // Stage 1: read data in flight
  logic               v1, first1, last1, zero1;
  logic [TAP_W-1:0]   tap1;
  logic [POS_W-1:0]   idx1;

  // Stage 2: product
  logic                     v2, first2, last2;
  logic [POS_W-1:0]         idx2;
  logic signed [PROD_W-1:0] prod;

  // Stage 3: accumulator
  logic                    v3;
  logic [POS_W-1:0]        idx3;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_next;

  assign samp_re    = running;
  assign samp_raddr = base + SAMP_AW'(idx) - SAMP_AW'(tap);

  assign acc_next = (first2 ? ACC_W'(0) : acc) + ACC_W'(prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      v1      <= 1'b0;
      v2      <= 1'b0;
      v3      <= 1'b0;
    end else begin
      if (ctrl.start) begin
        running <= 1'b1;
      end else if (running && tap == TAP_W'(TAPS - 1) && idx == POS_W'(BLOCK_LEN - 1)) begin
        running <= 1'b0;
      end
      v1 <= running;
      v2 <= v1;
      v3 <= v2 && last2;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      base   <= ctrl.base;
      primed <= ctrl.primed;
      idx    <= '0;
      tap    <= '0;
    end else if (running) begin
      if (tap == TAP_W'(TAPS - 1)) begin
        tap <= '0;
        idx <= idx + POS_W'(1);
      end else begin
        tap <= tap + TAP_W'(1);
      end
    end

    tap1   <= tap;
    idx1   <= idx;
    first1 <= (tap == '0);
    last1  <= (tap == TAP_W'(TAPS - 1));
    // Before the first block ends the history is all zero.
    zero1  <= !primed && (16'(idx) < 16'(tap));

    prod   <= zero1 ? PROD_W'(0) : $signed(samp_rdata) * coef[tap1];
    idx2   <= idx1;
    first2 <= first1;
    last2  <= last1;

    if (v2) begin
      acc <= acc_next;
    end
    idx3 <= idx2;
  end

  always_comb begin
    play_wr.we   = v3;
    play_wr.addr = idx3;
    play_wr.data = round_sat_q15(acc);
    stat.busy    = running || v1 || v2 || v3;
    stat.done    = v3 && idx3 == POS_W'(BLOCK_LEN - 1);
  end

endmodule

`default_nettype wire

// File: rtl/overlap_save_block_fir_top.sv
// Result path: an accepted request reads the play RAM; in ST_READ the sample then moves
//   into the output register once it is free and carries the filtered sample of the previous block.
// Requests: a new request is taken only in ST_IDLE, after the previous result has loaded;
//   a block's last request also waits for a filter pass (25 x 8 ring reads) on the one MAC.
// Reset (synchronous, active high) clears control state and coefficients; the
//   history and the first block's outputs read as zero.
`default_nettype none

module overlap_save_block_fir_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // input request channel
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic signed [osbfir_pkg::SAMP_W-1:0] sample_in,
  // output request channel
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [osbfir_pkg::SAMP_W-1:0]   sample_out,
  output logic                                   block_end,
  // coefficient write channel
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [osbfir_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [osbfir_pkg::SAMP_W-1:0]     cfg_data
);
  import osbfir_pkg::*;

  state_t state, state_next;

  logic               in_accept;
  logic               load;
  logic [POS_W-1:0]   pos;
  logic [SAMP_AW-1:0] wr_ptr;
  logic               pending_end;
  // Set once the first block is filtered: history and play RAM now hold data.
  logic               primed;

  sample_t   coef [TAPS];
  eng_ctrl_t ctrl;
  eng_stat_t stat;
  play_wr_t  play_wr;

  logic               samp_re;
  logic [SAMP_AW-1:0] samp_raddr;
  logic [SAMP_W-1:0]  samp_rdata;
  logic [SAMP_W-1:0]  play_rdata;

  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Coefficient registers; indexes past the tap count are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < TAPS; k++) begin
        coef[k] <= '0;
      end
    end else if (cfg_valid && cfg_ready && 32'(cfg_index) < NUM_COEF &&
                 32'(cfg_index) < TAPS) begin
      coef[cfg_index[TAP_W-1:0]] <= cfg_data;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) state_next = ST_READ;
      end
      ST_READ: begin
        if (load) state_next = pending_end ? ST_FILTER : ST_IDLE;
      end
      ST_FILTER: begin
        if (stat.done) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the state machine
  always_comb begin
    in_stall    = (state != ST_IDLE);
    // Move the play sample into the output register once it is free.
    load        = (state == ST_READ) && (!out_valid || !out_stall);
    ctrl.start  = load && pending_end;
    // Block start: the write pointer has already passed the whole block.
    ctrl.base   = wr_ptr - SAMP_AW'(BLOCK_LEN);
    ctrl.primed = primed;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      pos         <= '0;
      wr_ptr      <= '0;
      pending_end <= 1'b0;
      primed      <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (in_accept) begin
        pending_end <= (pos == POS_W'(BLOCK_LEN - 1));
        pos         <= (pos == POS_W'(BLOCK_LEN - 1)) ? '0 : pos + POS_W'(1);
        wr_ptr      <= wr_ptr + SAMP_AW'(1);
      end
      if (stat.done) begin
        primed <= 1'b1;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload; hold while stalled.
  always_ff @(posedge clk) begin
    if (load) begin
      sample_out <= primed ? play_rdata : '0;
      block_end  <= pending_end;
    end
  end

  // Sample ring: current block plus the history that precedes it.
  osbfir_ram #(
    .WIDTH (SAMP_W),
    .DEPTH (FFT_LEN)
  ) u_samp_ram (
    .clk   (clk),
    .we    (in_accept),
    .waddr (wr_ptr),
    .wdata (sample_in),
    .re    (samp_re),
    .raddr (samp_raddr),
    .rdata (samp_rdata)
  );

  // Play RAM: filtered samples of the previous block.
  osbfir_ram #(
    .WIDTH (SAMP_W),
    .DEPTH (BLOCK_LEN)
  ) u_play_ram (
    .clk   (clk),
    .we    (play_wr.we),
    .waddr (play_wr.addr),
    .wdata (play_wr.data),
    .re    (in_accept),
    .raddr (pos),
    .rdata (play_rdata)
  );

  osbfir_mac u_mac (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .coef       (coef),
    .samp_re    (samp_re),
    .samp_raddr (samp_raddr),
    .samp_rdata (samp_rdata),
    .play_wr    (play_wr),
    .stat       (stat)
  );

`ifndef NO_ASSERTIONS
  // No request may enter while the filter engine owns the RAMs.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    stat.busy |-> !in_accept)
    else $error("request accepted during filter pass");

  // The engine finishes only inside a filter pass.
  a_done_in_filter: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> state == ST_FILTER)
    else $error("filter done outside filter state");

  // A filter pass starts only on the last request of a block.
  a_start_block_end: assert property (@(posedge clk) disable iff (rst)
    ctrl.start |-> pos == '0)
    else $error("filter started mid-block");

  // A new result appears only after a play RAM read.
  a_load_after_read: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_READ)
    else $error("result without a read");
`endif

endmodule

`default_nettype wire
